/* rtl/spqv_pkg.sv */
// Package for the rotated sprite quad setup block.
// Holds the queued sprite record, corner codes and the quarter-wave sine generator.
// No dependencies.
package spqv_pkg;

  localparam int VERTS_PER_SPRITE = 6;
  localparam int QUEUE_DEPTH      = 2;
  localparam int IN_DATA_W        = 192;
  localparam int OUT_DATA_W       = 120;

  // pi in Q2.30.
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef enum logic [1:0] {
    CORNER_TL,
    CORNER_BL,
    CORNER_BR,
    CORNER_TR
  } corner_t;

  // One sprite after setup: the four rotated half-extent products, the
  // scaled centre, and everything the vertices copy through.
  typedef struct packed {
    logic signed [31:0] wc;
    logic signed [31:0] hs;
    logic signed [31:0] ws;
    logic signed [31:0] hc;
    logic signed [31:0] offx;
    logic signed [31:0] offy;
    logic [15:0]        u;
    logic [15:0]        v;
    logic [15:0]        su;
    logic [15:0]        sv;
    logic [31:0]        rgba;
    logic [15:0]        tex;
    logic               batch_begin;
  } sprite_t;

  // Vertex order within a sprite: TL, BL, BR, BR, TR, TL.
  function automatic corner_t vertex_corner(input logic [2:0] idx);
    corner_t c;
    case (idx)
      3'd0:    c = CORNER_TL;
      3'd1:    c = CORNER_BL;
      3'd2:    c = CORNER_BR;
      3'd3:    c = CORNER_BR;
      3'd4:    c = CORNER_TR;
      default: c = CORNER_TL;
    endcase
    return c;
  endfunction

  // Quarter-wave sine entry k in Q1.14, from a Q2.30 Taylor series.
  // Evaluated only while the table is built at elaboration.
  function automatic logic [14:0] quarter_sine(input int unsigned k, input int unsigned ab);
    longint unsigned kk;
    longint unsigned quarter;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned prod;
    longint          sum;
    quarter = 64'd1 << (ab - 2);
    kk = 64'(k);
    if (kk > quarter) begin
      kk = quarter;
    end
    x    = (PI_Q30 * kk + quarter) >> (ab - 1);
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      prod = (term * x2) >> 30;
      case (n)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        6:       term = prod / 64'd156;
        7:       term = prod / 64'd210;
        default: term = prod / 64'd272;
      endcase
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd32768) >>> 16;
    if (sum > 16384) begin
      sum = 16384;
    end
    return sum[14:0];
  endfunction

endpackage

/* rtl/spqv_front.sv */
// Front end of the sprite quad setup: accepts sprites, tracks texture batches,
// looks up sine and cosine and forms the rotated extents. Uses spqv_pkg.
module spqv_front
  import spqv_pkg::*;
#(
  parameter int ANGLE_BITS   = 12,
  parameter int TEXTURE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  output logic                  q_push,
  output sprite_t               q_data,
  input  logic                  q_full
);

  localparam int QUARTER = 1 << (ANGLE_BITS - 2);
  localparam int IW      = ANGLE_BITS - 1;

  // Constant quarter-wave table, one entry per step plus the top entry.
  logic [14:0] sine_tab [QUARTER + 1];
  for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
    assign sine_tab[g] = quarter_sine(g, ANGLE_BITS);
  end

  // Input fields.
  logic [15:0] f_px, f_py, f_w, f_h, f_u, f_v, f_su, f_sv, f_tex;
  logic [31:0] f_rgba;
  logic [11:0] f_turn;
  assign f_px   = in_tdata[15:0];
  assign f_py   = in_tdata[31:16];
  assign f_w    = in_tdata[47:32];
  assign f_h    = in_tdata[63:48];
  assign f_u    = in_tdata[79:64];
  assign f_v    = in_tdata[95:80];
  assign f_su   = in_tdata[111:96];
  assign f_sv   = in_tdata[127:112];
  assign f_rgba = in_tdata[159:128];
  assign f_tex  = in_tdata[175:160];
  assign f_turn = in_tdata[187:176];

  logic [ANGLE_BITS+11:0]   turn_ext;
  logic [ANGLE_BITS-1:0]    ang;
  logic [ANGLE_BITS-3:0]    ang_rem;
  logic [IW-1:0]            addr_r;
  logic [IW-1:0]            addr_q;
  logic [TEXTURE_BITS+15:0] tex_ext;
  logic [TEXTURE_BITS-1:0]  tex_m;
  logic [TEXTURE_BITS+15:0] tex_back;
  logic                     new_batch;

  assign turn_ext = {ANGLE_BITS'(0), f_turn};
  assign ang      = turn_ext[ANGLE_BITS-1:0];
  assign ang_rem  = ang[ANGLE_BITS-3:0];
  assign addr_r   = {1'b0, ang_rem};
  assign addr_q   = IW'(QUARTER) - {1'b0, ang_rem};
  assign tex_ext  = {16'd0, f_tex};
  assign tex_m    = tex_ext[TEXTURE_BITS-1:0];
  assign tex_back = {16'd0, tex_m};

  // Batch tracking state.
  logic [TEXTURE_BITS-1:0] prev_tex_r;
  logic                    have_prev_r;

  assign new_batch = in_tuser || !have_prev_r || (tex_m != prev_tex_r);

  // Stage A: table read and captured fields.
  logic        a_vld_r;
  logic [14:0] a_tr_r, a_tq_r;
  logic [1:0]  a_quad_r;
  logic [15:0] a_px_r, a_py_r, a_w_r, a_h_r, a_u_r, a_v_r, a_su_r, a_sv_r, a_tex_r;
  logic [31:0] a_rgba_r;
  logic        a_batch_r;

  // Stage B: finished sprite record.
  logic    b_vld_r;
  sprite_t b_r;
  sprite_t b_nxt;

  logic a_ready;
  logic b_ready;
  logic accept;

  assign b_ready   = !b_vld_r || !q_full;
  assign a_ready   = !a_vld_r || b_ready;
  assign in_tready = a_ready;
  assign accept    = in_tvalid && a_ready;
  assign q_push    = b_vld_r && !q_full;
  assign q_data    = b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      prev_tex_r  <= '0;
      have_prev_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_vld_r <= in_tvalid;
      end
      if (b_ready) begin
        b_vld_r <= a_vld_r;
      end
      if (accept) begin
        prev_tex_r  <= tex_m;
        have_prev_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_tr_r    <= sine_tab[addr_r];
      a_tq_r    <= sine_tab[addr_q];
      a_quad_r  <= ang[ANGLE_BITS-1:ANGLE_BITS-2];
      a_px_r    <= f_px;
      a_py_r    <= f_py;
      a_w_r     <= f_w;
      a_h_r     <= f_h;
      a_u_r     <= f_u;
      a_v_r     <= f_v;
      a_su_r    <= f_su;
      a_sv_r    <= f_sv;
      a_rgba_r  <= f_rgba;
      a_tex_r   <= tex_back[15:0];
      a_batch_r <= new_batch;
    end
    if (b_ready) begin
      b_r <= b_nxt;
    end
  end

  // Quadrant folding of the table values into sine and cosine.
  logic signed [15:0] tr_s, tq_s, sin_s, cos_s;
  logic signed [32:0] wc_full, hs_full, ws_full, hc_full;
  logic signed [17:0] cen_x, cen_y;

  always_comb begin
    tr_s = $signed({1'b0, a_tr_r});
    tq_s = $signed({1'b0, a_tq_r});
    case (a_quad_r)
      2'd0: begin
        sin_s = tr_s;
        cos_s = tq_s;
      end
      2'd1: begin
        sin_s = tq_s;
        cos_s = -tr_s;
      end
      2'd2: begin
        sin_s = -tr_s;
        cos_s = -tq_s;
      end
      default: begin
        sin_s = -tq_s;
        cos_s = tr_s;
      end
    endcase
  end

  assign wc_full = $signed({1'b0, a_w_r}) * cos_s;
  assign hs_full = $signed({1'b0, a_h_r}) * sin_s;
  assign ws_full = $signed({1'b0, a_w_r}) * sin_s;
  assign hc_full = $signed({1'b0, a_h_r}) * cos_s;
  assign cen_x   = $signed({a_px_r[15], a_px_r, 1'b0}) + $signed({2'b00, a_w_r});
  assign cen_y   = $signed({a_py_r[15], a_py_r, 1'b0}) + $signed({2'b00, a_h_r});

  always_comb begin
    b_nxt.wc          = wc_full[31:0];
    b_nxt.hs          = hs_full[31:0];
    b_nxt.ws          = ws_full[31:0];
    b_nxt.hc          = hc_full[31:0];
    b_nxt.offx        = {cen_x, 14'd0};
    b_nxt.offy        = {cen_y, 14'd0};
    b_nxt.u           = a_u_r;
    b_nxt.v           = a_v_r;
    b_nxt.su          = a_su_r;
    b_nxt.sv          = a_sv_r;
    b_nxt.rgba        = a_rgba_r;
    b_nxt.tex         = a_tex_r;
    b_nxt.batch_begin = a_batch_r;
  end

`ifndef SYNTH
  a_frame_forces_batch: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> a_batch_r)
    else $error("frame start did not force a new batch");
`endif

endmodule

/* rtl/spqv_queue.sv */
// Short queue of set-up sprites between the front and back ends.
// Uses spqv_pkg for the sprite record and depth.
module spqv_queue
  import spqv_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  sprite_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output sprite_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sprite_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into a full sprite queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop)
    else $error("pop from an empty sprite queue");
`endif

endmodule

/* rtl/spqv_back.sv */
// Back end of the sprite quad setup: walks the six vertices of the sprite
// at the queue head and drives the registered output stream. Uses spqv_pkg.
module spqv_back
  import spqv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_not_empty,
  input  sprite_t                q_head,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  logic [2:0]            vidx_r;
  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;
  logic                  out_last_r;

  logic                  load;
  logic                  last_of_sprite;
  corner_t               corner;
  logic                  pos_x_side, pos_y_side;
  logic signed [33:0]    wc_e, hs_e, ws_e, hc_e, offx_e, offy_e;
  logic signed [33:0]    sum_x, sum_y;
  logic [16:0]           vu, vv;
  logic [OUT_DATA_W-1:0] data_nxt;

  assign load           = q_not_empty && (!out_vld_r || out_tready);
  assign last_of_sprite = (vidx_r == 3'(VERTS_PER_SPRITE - 1));
  assign q_pop          = load && last_of_sprite;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    corner     = vertex_corner(vidx_r);
    pos_x_side = (corner == CORNER_BR) || (corner == CORNER_TR);
    pos_y_side = (corner == CORNER_TL) || (corner == CORNER_TR);

    wc_e   = 34'(q_head.wc);
    hs_e   = 34'(q_head.hs);
    ws_e   = 34'(q_head.ws);
    hc_e   = 34'(q_head.hc);
    offx_e = 34'(q_head.offx);
    offy_e = 34'(q_head.offy);

    // x = cx*c - cy*s + centre, y = cx*s + cy*c + centre, with the
    // corner signs folded in; the extra term rounds to nearest.
    sum_x = (pos_x_side ? wc_e : -wc_e) + (pos_y_side ? -hs_e : hs_e)
          + offx_e + 34'sd16384;
    sum_y = (pos_x_side ? ws_e : -ws_e) + (pos_y_side ? hc_e : -hc_e)
          + offy_e + 34'sd16384;

    vu = pos_x_side ? ({1'b0, q_head.u} + {1'b0, q_head.su}) : {1'b0, q_head.u};
    vv = pos_y_side ? ({1'b0, q_head.v} + {1'b0, q_head.sv}) : {1'b0, q_head.v};

    data_nxt = {q_head.tex, q_head.rgba, vv, vu, sum_y[33:15], sum_x[33:15]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vidx_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (load) begin
        out_vld_r <= 1'b1;
        vidx_r    <= last_of_sprite ? 3'd0 : vidx_r + 3'd1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= data_nxt;
      out_user_r <= (vidx_r == 3'd0) && q_head.batch_begin;
      out_last_r <= last_of_sprite;
    end
  end

`ifndef SYNTH
  a_vidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    vidx_r <= 3'(VERTS_PER_SPRITE - 1))
    else $error("vertex index out of range");
  a_batch_first_only: assert property (@(posedge clk) disable iff (!rst_n)
    load && (vidx_r != 3'd0) |=> !out_user_r)
    else $error("batch start flagged on a vertex other than the first");
`endif

endmodule

/* rtl/sprite_quad_vertex_expander_top.sv */
// Top level of the rotated sprite quad setup block.
// Instantiates spqv_front, spqv_queue and spqv_back; uses spqv_pkg.
//
// Each sprite transfer on the input stream produces six vertex transfers on
// the output stream, in the order top-left, bottom-left, bottom-right,
// bottom-right, top-right, top-left, with out_tlast on the sixth. Corners
// are rotated counter-clockwise about the sprite centre using a quarter-wave
// sine table in Q1.14, and positions are rounded to the nearest 1/16 pixel.
// out_tuser marks the first vertex of a sprite that opens a new texture
// batch: the first sprite after reset, a sprite with in_tuser (frame start)
// set, or a sprite whose texture handle differs from the previous one. The
// front end takes one sprite per cycle while the queue has room, through a
// table read stage and a multiply stage into a two-entry queue; the back
// end emits one vertex per cycle while out_tready is high, from the
// registered output stage. The single output port delivering six vertices
// per sprite sets the sustained rate. A sprite passes both front stages and
// the queue before its first vertex loads the output stage. The sine table
// has 2^(ANGLE_BITS-2)+1 constant entries, read at two addresses per sprite.
module sprite_quad_vertex_expander_top
  import spqv_pkg::*;
#(
  parameter int ANGLE_BITS   = 12,
  parameter int TEXTURE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // From bit 0: pos_x[16], pos_y[16], size_w[16], size_h[16], tex_u[16],
  // tex_v[16], tex_span_u[16], tex_span_v[16], rgba[32], texture_id[16],
  // turn[12], four zero pad bits.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // frame_start.
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // From bit 0: vert_x[19], vert_y[19], vert_u[17], vert_v[17],
  // vert_rgba[32], vert_texture[16].
  output logic [OUT_DATA_W-1:0] out_tdata,
  // batch_begin.
  output logic                  out_tuser,
  // last_vertex.
  output logic                  out_tlast
);

  logic    q_push;
  sprite_t q_push_data;
  logic    q_full;
  logic    q_pop;
  logic    q_not_empty;
  sprite_t q_head;

  spqv_front #(
    .ANGLE_BITS   (ANGLE_BITS),
    .TEXTURE_BITS (TEXTURE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (q_push),
    .q_data    (q_push_data),
    .q_full    (q_full)
  );

  // The queue lets the front end keep accepting sprites while a vertex
  // is stalled at the output.
  spqv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  spqv_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

/* dv/sprite_quad_vertex_expander_top_tb.sv */
// Self-checking testbench for sprite_quad_vertex_expander_top.
// Holds its own rotation and batch predictor and a per-vertex checker.
// Depends on rtl/spqv_pkg.sv and the RTL of the block.
module sprite_quad_vertex_expander_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Angle resolution of the block as built, and the size of one quarter turn.
  localparam int ANGLE_BITS  = 12;
  localparam int QUARTER     = 1 << (ANGLE_BITS - 2);
  // pi in Q2.30, the seed of the sine series.
  localparam longint unsigned PI_Q2_30 = 64'd3373259426;
  localparam int VERTS       = 6;
  localparam int CYCLE_LIMIT = 200_000;

  // Corner visited by each of the six vertices of a sprite.
  localparam spqv_pkg::corner_t VERTEX_ORDER [VERTS] = '{
    spqv_pkg::CORNER_TL, spqv_pkg::CORNER_BL, spqv_pkg::CORNER_BR,
    spqv_pkg::CORNER_BR, spqv_pkg::CORNER_TR, spqv_pkg::CORNER_TL
  };

  // One sprite as it travels on the input stream.
  typedef struct {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        size_w;
    logic [15:0]        size_h;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [15:0]        span_u;
    logic [15:0]        span_v;
    logic [31:0]        rgba;
    logic [15:0]        texture;
    logic [11:0]        turn;
    logic               frame_start;
  } sprite_rec_t;

  // One vertex as it travels on the output stream.
  typedef struct {
    logic [18:0] x;
    logic [18:0] y;
    logic [16:0] u;
    logic [16:0] v;
    logic [31:0] rgba;
    logic [15:0] texture;
    logic        batch_begin;
    logic        last_vertex;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [spqv_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic                           in_tuser = 1'b0;

  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [spqv_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            out_tlast;

  // Quarter-wave sine in Q1.14, entries 0 through QUARTER inclusive.
  int sine_lut [0:QUARTER];

  // Predictor state: texture of the last accepted sprite and whether one was seen.
  logic [15:0] prev_texture;
  logic        have_prev_texture;

  // Vertices predicted from accepted sprites and not yet seen on the output.
  vertex_t pending_vertices [$];

  // Idle percentages for the sender and the receiver, set per phase.
  int sender_gap_pct  = 0;
  int receiver_stall_pct = 0;

  int error_count  = 0;
  int sprite_count = 0;
  int vertex_count = 0;
  int cycle_count  = 0;

  always #4 clk = ~clk;

  sprite_quad_vertex_expander_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // The receiver decides once per cycle whether to stall; a single
  // nonblocking update per edge keeps the ready line free of races.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Cycle counter and watchdog. A correct run finishes far below the limit,
  // even with every vertex waiting out the longest receiver stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("sprite_quad_vertex_expander_top_tb: FAIL");
    $finish;
  end

  // Compares one output field with its prediction and reports a mismatch.
  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Each vertex transfer is checked against the oldest predicted vertex.
  // Signals are read at the edge, before any update scheduled for it lands.
  always @(posedge clk) begin : vertex_check
    vertex_t want;
    if (rst_n && out_tvalid && out_tready) begin
      vertex_count++;
      if (pending_vertices.size() == 0) begin
        $error("vertex transfer with no sprite outstanding");
        error_count++;
      end else begin
        want = pending_vertices.pop_front();
        check_field("vert_x", $signed(want.x), $signed(out_tdata[18:0]));
        check_field("vert_y", $signed(want.y), $signed(out_tdata[37:19]));
        check_field("vert_u", want.u, out_tdata[54:38]);
        check_field("vert_v", want.v, out_tdata[71:55]);
        check_field("vert_rgba", want.rgba, out_tdata[103:72]);
        check_field("vert_texture", want.texture, out_tdata[119:104]);
        check_field("batch_begin", want.batch_begin, out_tuser);
        check_field("last_vertex", want.last_vertex, out_tlast);
      end
    end
  end

  // Rotates the four corners of an accepted sprite about its centre and
  // queues its six vertices. Positions are kept in 1/32 pixel scaled by the
  // Q1.14 sine, so the final shift by 15 lands on 1/16 pixel, rounding half up.
  task automatic predict_vertices(input sprite_rec_t sp);
    longint px, py, w, h, c, s, cx, cy, offx, offy, nx, ny;
    longint lo_sine, hi_sine;
    logic signed [63:0] rx, ry;
    logic [ANGLE_BITS-3:0] within_quarter;
    logic opens_batch;
    spqv_pkg::corner_t crn;
    vertex_t vt;
    px = sp.pos_x;
    py = sp.pos_y;
    w  = sp.size_w;
    h  = sp.size_h;
    within_quarter = sp.turn[ANGLE_BITS-3:0];
    lo_sine = sine_lut[within_quarter];
    hi_sine = sine_lut[QUARTER - within_quarter];
    // The quadrant picks which table reading serves as sine and cosine.
    case (sp.turn[ANGLE_BITS-1:ANGLE_BITS-2])
      2'd0: begin
        s = lo_sine;
        c = hi_sine;
      end
      2'd1: begin
        s = hi_sine;
        c = -lo_sine;
      end
      2'd2: begin
        s = -lo_sine;
        c = -hi_sine;
      end
      default: begin
        s = -hi_sine;
        c = lo_sine;
      end
    endcase
    opens_batch = sp.frame_start || !have_prev_texture || (sp.texture != prev_texture);
    prev_texture = sp.texture;
    have_prev_texture = 1'b1;
    offx = (2 * px + w) * 16384;
    offy = (2 * py + h) * 16384;
    for (int k = 0; k < VERTS; k++) begin
      crn = VERTEX_ORDER[k];
      cx = (crn == spqv_pkg::CORNER_BR || crn == spqv_pkg::CORNER_TR) ? w : -w;
      cy = (crn == spqv_pkg::CORNER_TL || crn == spqv_pkg::CORNER_TR) ? h : -h;
      nx = cx * c - cy * s + offx;
      ny = cx * s + cy * c + offy;
      rx = (nx + 64'sd16384) >>> 15;
      ry = (ny + 64'sd16384) >>> 15;
      vt.x = rx[18:0];
      vt.y = ry[18:0];
      vt.u = (cx > 0 || (cx == 0 && (crn == spqv_pkg::CORNER_BR ||
              crn == spqv_pkg::CORNER_TR))) ?
             {1'b0, sp.tex_u} + {1'b0, sp.span_u} : {1'b0, sp.tex_u};
      vt.v = (crn == spqv_pkg::CORNER_TL || crn == spqv_pkg::CORNER_TR) ?
             {1'b0, sp.tex_v} + {1'b0, sp.span_v} : {1'b0, sp.tex_v};
      vt.rgba = sp.rgba;
      vt.texture = sp.texture;
      vt.batch_begin = (k == 0) && opens_batch;
      vt.last_vertex = (k == VERTS - 1);
      pending_vertices.push_back(vt);
    end
  endtask

  // Offers one sprite on the input stream, after a random gap when the phase
  // asks for one, and holds it until the block takes the transfer.
  task automatic send_sprite(input sprite_rec_t sp);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= sp.frame_start;
    in_tdata  <= {4'b0000, sp.turn, sp.texture, sp.rgba, sp.span_v, sp.span_u,
                  sp.tex_v, sp.tex_u, sp.size_h, sp.size_w, sp.pos_y, sp.pos_x};
    @(posedge clk);
    while (in_tready !== 1'b1) begin
      @(posedge clk);
    end
    sprite_count++;
    predict_vertices(sp);
  endtask

  function automatic sprite_rec_t make_sprite(
      input logic [15:0] px, input logic [15:0] py, input logic [15:0] w,
      input logic [15:0] h, input logic [15:0] u, input logic [15:0] v,
      input logic [15:0] su, input logic [15:0] sv, input logic [31:0] rgba,
      input logic [15:0] tex, input logic [11:0] turn, input logic fs);
    sprite_rec_t sp;
    sp.pos_x = px;
    sp.pos_y = py;
    sp.size_w = w;
    sp.size_h = h;
    sp.tex_u = u;
    sp.tex_v = v;
    sp.span_u = su;
    sp.span_v = sv;
    sp.rgba = rgba;
    sp.texture = tex;
    sp.turn = turn;
    sp.frame_start = fs;
    return sp;
  endfunction

  // Random sprite. Half of them reuse the previous texture so that batches
  // continue, a few start a frame, and some angles sit on quadrant seams.
  function automatic sprite_rec_t random_sprite();
    sprite_rec_t sp;
    sp = make_sprite(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     $urandom, 16'($urandom), 12'($urandom),
                     ($urandom_range(9) == 0));
    if ($urandom_range(3) == 0) begin
      sp.size_w = 16'($urandom_range(0, 255));
      sp.size_h = 16'($urandom_range(0, 255));
    end
    if ($urandom_range(1) == 0 && have_prev_texture) begin
      sp.texture = prev_texture;
    end
    case ($urandom_range(9))
      0: sp.turn[ANGLE_BITS-3:0] = '0;
      1: sp.turn[ANGLE_BITS-3:0] = '1;
      2: sp.turn[ANGLE_BITS-3:0] = (ANGLE_BITS-2)'(1);
      default: ;
    endcase
    return sp;
  endfunction

  task automatic send_random_sprites(input int count);
    repeat (count) begin
      send_sprite(random_sprite());
    end
  endtask

  task automatic wait_all_vertices();
    while (pending_vertices.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Field extremes, every quadrant seam, rounding ties, carries out of the
  // texture sums, zero-sized quads and each reason a batch opens or not.
  task automatic test_corner_cases();
    sender_gap_pct = 0;
    receiver_stall_pct = 0;
    // First sprite after reset opens a batch even though its texture matches
    // the cleared previous texture.
    send_sprite(make_sprite(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                            16'h0000, 16'h0000, 32'h0000_0000, 16'h0000, 12'd0, 1'b0));
    // Same texture again, no frame start: batch continues.
    send_sprite(make_sprite(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                            16'h0000, 16'h0000, 32'h0000_0000, 16'h0000, 12'd0, 1'b0));
    send_sprite(make_sprite(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h1234, 16'h4321,
                            16'h0100, 16'h0200, 32'h1234_5678, 16'h0000, 12'd2048, 1'b0));
    // Frame start forces a new batch on an unchanged texture.
    send_sprite(make_sprite(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h8000, 16'h8000,
                            16'h8000, 16'h8000, 32'h8000_0001, 16'h0000, 12'd1024, 1'b1));
    // Texture sums carry into bit 16.
    send_sprite(make_sprite(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 12'd3072, 1'b0));
    send_sprite(make_sprite(16'hFFFF, 16'h0001, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF,
                            16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF, 12'd4095, 1'b0));
    // Odd sizes at zero and half-turn angles: the centre sits on a half step, the corners land exactly.
    send_sprite(make_sprite(16'h0003, 16'hFFFD, 16'h0001, 16'h0003, 16'h0010, 16'h0020,
                            16'h0001, 16'h0001, 32'hA5A5_A5A5, 16'hAAAA, 12'd0, 1'b0));
    send_sprite(make_sprite(16'hFFFB, 16'h0005, 16'h0005, 16'h0007, 16'h5555, 16'hAAAA,
                            16'hAAAA, 16'h5555, 32'h5A5A_5A5A, 16'h5555, 12'd2048, 1'b0));
    // Angles one step either side of the seams at 1024, 2048 and 3072, and one past zero.
    send_sprite(make_sprite(16'h0100, 16'h0200, 16'h0400, 16'h0300, 16'h0000, 16'h0000,
                            16'h1000, 16'h1000, 32'h0102_0304, 16'h5555, 12'd1, 1'b0));
    send_sprite(make_sprite(16'hFF00, 16'h0200, 16'h1400, 16'h0030, 16'h0000, 16'h0000,
                            16'h1000, 16'h1000, 32'h0102_0304, 16'h5555, 12'd1023, 1'b0));
    send_sprite(make_sprite(16'h0100, 16'hFE00, 16'h0401, 16'h2301, 16'h0000, 16'h0000,
                            16'h1000, 16'h1000, 32'h0102_0304, 16'h5555, 12'd1025, 1'b0));
    send_sprite(make_sprite(16'h4000, 16'hC000, 16'h7FFF, 16'h8001, 16'h0000, 16'h0000,
                            16'h1000, 16'h1000, 32'h0102_0304, 16'h5555, 12'd2047, 1'b0));
    send_sprite(make_sprite(16'hC000, 16'h4000, 16'hFFFF, 16'h0FFF, 16'h0000, 16'h0000,
                            16'h1000, 16'h1000, 32'h0102_0304, 16'h5555, 12'd2049, 1'b0));
    send_sprite(make_sprite(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                            16'h1000, 16'h1000, 32'h0102_0304, 16'h5555, 12'd3071, 1'b0));
    send_sprite(make_sprite(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                            16'h1000, 16'h1000, 32'h0102_0304, 16'h5555, 12'd3073, 1'b0));
    // Forty-five degrees, then a zero-sized quad collapsing to its corner.
    send_sprite(make_sprite(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF,
                            16'h8001, 16'h8001, 32'h0000_00FF, 16'h0001, 12'd512, 1'b0));
    send_sprite(make_sprite(16'h1234, 16'hEDCB, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
                            16'h0000, 16'hFFFF, 32'hFF00_0000, 16'h0002, 12'd700, 1'b0));
    send_sprite(make_sprite(16'h1234, 16'hEDCB, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000,
                            16'h0000, 16'h0000, 32'h00FF_00FF, 16'h0002, 12'd3500, 1'b1));
    in_tvalid <= 1'b0;
    wait_all_vertices();
  endtask

  task automatic test_back_to_back();
    sender_gap_pct = 0;
    receiver_stall_pct = 0;
    send_random_sprites(100);
  endtask

  task automatic test_sender_gaps();
    sender_gap_pct = 63;
    receiver_stall_pct = 0;
    send_random_sprites(100);
  endtask

  task automatic test_receiver_stalls();
    sender_gap_pct = 0;
    receiver_stall_pct = 63;
    send_random_sprites(100);
  endtask

  task automatic test_mixed_idle();
    sender_gap_pct = 20;
    receiver_stall_pct = 20;
    send_random_sprites(80);
  endtask

  // The sender holds off until every predicted vertex has left the block,
  // so the pipeline restarts from empty with the batch state carried over.
  task automatic test_pause_until_drained();
    sender_gap_pct = 0;
    receiver_stall_pct = 20;
    send_random_sprites(20);
    in_tvalid <= 1'b0;
    wait_all_vertices();
    @(posedge clk);
    send_random_sprites(20);
  endtask

  initial begin : main
    longint unsigned x, x2, term;
    longint acc;
    // Build the quarter-wave table: a Taylor series for sine in Q2.30 with
    // terms through x^17, each term truncated, then rounded to Q1.14.
    for (int k = 0; k <= QUARTER; k++) begin
      x = (PI_Q2_30 * longint'(k) + QUARTER) >> (ANGLE_BITS - 1);
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        acc = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) begin
        acc = 0;
      end
      acc = (acc + 32768) >>> 16;
      sine_lut[k] = (acc > 16384) ? 16384 : int'(acc);
    end
    prev_texture = '0;
    have_prev_texture = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_cases();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idle();
    test_pause_until_drained();

    // All sprites are in; let the last vertices drain, then keep watching the
    // output so that any stray extra vertex would still be caught.
    in_tvalid <= 1'b0;
    wait_all_vertices();
    repeat (16) @(posedge clk);

    $display("Sent %0d sprites and checked %0d vertices: edge cases, all quadrants,",
             sprite_count, vertex_count);
    $display("batch breaks, and phases with sender gaps, receiver stalls and a full drain.");
    if (error_count == 0 && pending_vertices.size() == 0) begin
      $display("sprite_quad_vertex_expander_top_tb: PASS");
    end else begin
      $display("sprite_quad_vertex_expander_top_tb: FAIL");
    end
    $finish;
  end

endmodule
